// File: rtl/chained_hash_table_engine_top_macros.svh
// assertion macros for the hash table engine checker
`ifndef CHAINED_HASH_TABLE_ENGINE_TOP_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_TOP_MACROS_SVH
// implication checked every clock, held off during reset
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg
// shared types and constants of the chained hash table engine
// ---------------------------------------------------------------------------
package cht_pkg;
	localparam int BUCKETS_DEF    = 1024;
	localparam int ENTRIES_DEF    = 1024;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int VALUE_BITS_DEF = 32;
	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam logic [2:0]  MAX_SELECT = 3'd6;

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_REM = 2'd2;

	localparam logic [0:0] REG_SIZE_SELECT = 1'b0;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD, ST_WALK, ST_ALLOC, ST_RELINK, ST_DONE
	} state_t;
endpackage

// File: rtl/cht_hash.sv
// ---------------------------------------------------------------------------
// cht_hash
// djb2 hash over the key bytes, one byte per cycle
// ---------------------------------------------------------------------------
module cht_hash #(
	parameter int KEY_BYTES = cht_pkg::KEY_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [8*KEY_BYTES-1:0] key,
	input  logic [3:0]             len,
	output logic                   done,
	output logic [31:0]            hash
);
	logic [3:0]             cnt_q;
	logic                   busy_q;
	logic [8*KEY_BYTES-1:0] key_q;
	logic [31:0]            h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= len;
		end else if (busy_q) begin
			if (cnt_q == 4'd0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
			h_q   <= cht_pkg::HASH_SEED;
		end else if (busy_q && cnt_q != 4'd0) begin
			h_q   <= (h_q << 5) + h_q + {24'd0, key_q[7:0]};
			key_q <= key_q >> 8;
		end
	end

	assign done = busy_q && (cnt_q == 4'd0);
	assign hash = h_q;
endmodule

// File: rtl/chained_hash_table_engine_top.sv
// ---------------------------------------------------------------------------
// chained_hash_table_engine_top
// key/value store with separate chaining, heads and entries in block memory
// ---------------------------------------------------------------------------
// channel  direction  handshake         contents
// s_axis   in         tvalid/tready     operation, key, length, value
// m_axis   out        tvalid/tready     found, value, full, entry count
// apb      in         psel/penable      size_select at address 0
//
// an item goes through the hash of its key bytes, a read of the bucket head,
// a walk of the chain entry by entry, on a miss an allocation state and a
// relink state when the slot comes off the recycled list, then a done state.
// an unused operation code goes straight to the done state.
// after reset the bucket head memory is cleared, one bucket a cycle, before
// the first request is taken.
// one request in flight; the result waits in an output register and the
// next request is accepted the cycle after it is taken.
module chained_hash_table_engine_top #(
	parameter int BUCKETS    = cht_pkg::BUCKETS_DEF,
	parameter int ENTRIES    = cht_pkg::ENTRIES_DEF,
	parameter int KEY_BYTES  = cht_pkg::KEY_BYTES_DEF,
	parameter int VALUE_BITS = cht_pkg::VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[1:0], key_bytes[65:2], key_length[69:66], value[101:70], pad
	input  logic [103:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// found[0], result_value[32:1], full_res[33], entry_count[44:34], pad
	output logic [47:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int KW = 8 * KEY_BYTES;
	localparam int VW = VALUE_BITS;
	// entry word: key, length, value
	localparam int DW = KW + 4 + VW;

	// configuration
	logic [2:0] size_select_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_select_q <= '0;
		else if (psel && penable && pwrite && paddr == {cht_pkg::REG_SIZE_SELECT, 1'b0})
			size_select_q <= pwdata[2:0];
	end
	assign prdata = (paddr == {cht_pkg::REG_SIZE_SELECT, 1'b0}) ? {29'd0, size_select_q} : '0;

	// memories: heads {valid, index}, entry data, entry links {valid, index}
	logic [EW:0]   head_mem [BUCKETS];
	logic [DW-1:0] ent_mem  [ENTRIES];
	logic [EW:0]   link_mem [ENTRIES];

	cht_pkg::state_t st_q, st_d;

	// request registers
	logic [1:0]    op_q;
	logic [KW-1:0] key_q;
	logic [3:0]    len_q;
	logic [VW-1:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [EW-1:0] cur_q, prev_q;
	logic          have_prev_q;
	logic [BW:0]   clr_q;
	logic [EW:0]   recyc_q;
	logic [CW-1:0] fresh_q, total_q;
	logic          out_valid_q;
	logic          found_q, full_q;
	logic [31:0]   rval_q;

	// memory read data
	logic [EW:0]   head_rd;
	logic [DW-1:0] ent_rd;
	logic [EW:0]   link_rd;

	// saturated length and masked key of the incoming request
	logic [3:0]    in_len;
	logic [KW-1:0] in_key;
	always_comb begin
		in_len = (s_axis_tdata[69:66] > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : s_axis_tdata[69:66];
		for (int i = 0; i < KEY_BYTES; i++)
			in_key[8*i +: 8] = (4'(i) < in_len) ? s_axis_tdata[2 + 8*i +: 8] : 8'd0;
	end

	logic        accept;
	logic        hash_done;
	logic [31:0] hash;
	assign s_axis_tready = (st_q == cht_pkg::ST_IDLE) && !out_valid_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	cht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(accept), .key(in_key), .len(in_len),
		.done(hash_done), .hash(hash)
	);

	logic [2:0]    sel;
	logic [BW-1:0] bmask;
	assign sel   = (size_select_q > cht_pkg::MAX_SELECT) ? cht_pkg::MAX_SELECT : size_select_q;
	assign bmask = BW'({BW{1'b1}} >> sel);

	// hit test on the entry read back
	logic hit;
	assign hit = (ent_rd[KW +: 4] == len_q) && (ent_rd[KW-1:0] == key_q);

	// slot for a new entry: recycled list first, then the fresh pool
	logic          new_slot_ok;
	logic [EW-1:0] new_slot;
	assign new_slot_ok = recyc_q[EW] || (fresh_q < CW'(ENTRIES));
	assign new_slot    = recyc_q[EW] ? recyc_q[EW-1:0] : fresh_q[EW-1:0];

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			cht_pkg::ST_CLEAR:  if (clr_q == (BW+1)'(BUCKETS - 1)) st_d = cht_pkg::ST_IDLE;
			cht_pkg::ST_IDLE:   if (accept) st_d = (s_axis_tdata[1:0] <= cht_pkg::OP_REM)
			                                      ? cht_pkg::ST_HASH : cht_pkg::ST_DONE;
			cht_pkg::ST_HASH:   if (hash_done) st_d = cht_pkg::ST_HEAD;
			cht_pkg::ST_HEAD:   st_d = head_rd[EW] ? cht_pkg::ST_WALK : cht_pkg::ST_ALLOC;
			cht_pkg::ST_WALK:   st_d = hit ? cht_pkg::ST_DONE
			                           : (link_rd[EW] ? cht_pkg::ST_WALK : cht_pkg::ST_ALLOC);
			cht_pkg::ST_ALLOC:  st_d = (op_q == cht_pkg::OP_SET && new_slot_ok && recyc_q[EW])
			                           ? cht_pkg::ST_RELINK : cht_pkg::ST_DONE;
			cht_pkg::ST_RELINK: st_d = cht_pkg::ST_DONE;
			cht_pkg::ST_DONE:   st_d = cht_pkg::ST_IDLE;
			default:            st_d = cht_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= cht_pkg::ST_CLEAR;
		else st_q <= st_d;
	end

	// read addresses: head on hash done, entry on head hit or walk miss,
	// recycled link on allocation
	logic [EW-1:0] ent_ra;
	logic          ent_re;
	always_comb begin
		ent_re = 1'b0;
		ent_ra = cur_q;
		priority if (st_q == cht_pkg::ST_HEAD && head_rd[EW]) begin
			ent_re = 1'b1; ent_ra = head_rd[EW-1:0];
		end else if (st_q == cht_pkg::ST_WALK && !hit && link_rd[EW]) begin
			ent_re = 1'b1; ent_ra = link_rd[EW-1:0];
		end else if (st_q == cht_pkg::ST_ALLOC) begin
			ent_re = 1'b1; ent_ra = recyc_q[EW-1:0];
		end else begin
			ent_re = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == cht_pkg::ST_HASH && hash_done) head_rd <= head_mem[hash[BW-1:0] & bmask];
		if (ent_re) begin
			ent_rd  <= ent_mem[ent_ra];
			link_rd <= link_mem[ent_ra];
		end
	end

	// writes and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			recyc_q     <= '0;
			fresh_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
			if (st_q == cht_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == cht_pkg::ST_DONE) out_valid_q <= 1'b1;
			if (st_q == cht_pkg::ST_WALK && hit && op_q == cht_pkg::OP_REM) begin
				recyc_q <= {1'b1, cur_q};
				if (total_q != '0) total_q <= total_q - 1'b1;
			end
			if (st_q == cht_pkg::ST_ALLOC && op_q == cht_pkg::OP_SET && new_slot_ok) begin
				total_q <= total_q + 1'b1;
				if (!recyc_q[EW]) fresh_q <= fresh_q + 1'b1;
			end
			if (st_q == cht_pkg::ST_RELINK) recyc_q <= link_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == cht_pkg::ST_CLEAR) head_mem[clr_q[BW-1:0]] <= '0;
		if (accept) begin
			op_q        <= s_axis_tdata[1:0];
			key_q       <= in_key;
			len_q       <= in_len;
			val_q       <= VW'(s_axis_tdata[101:70]);
			have_prev_q <= 1'b0;
			found_q     <= 1'b0;
			full_q      <= 1'b0;
			rval_q      <= '0;
		end
		if (st_q == cht_pkg::ST_HASH && hash_done) bkt_q <= hash[BW-1:0] & bmask;
		if (ent_re && st_q != cht_pkg::ST_ALLOC) cur_q <= ent_ra;
		if (st_q == cht_pkg::ST_WALK) begin
			if (hit) begin
				found_q <= 1'b1;
				unique case (op_q)
					cht_pkg::OP_SET: ent_mem[cur_q] <= {val_q, len_q, key_q};
					cht_pkg::OP_GET: rval_q <= 32'(ent_rd[KW+4 +: VW]);
					default: begin
						if (have_prev_q) link_mem[prev_q] <= link_rd;
						else head_mem[bkt_q] <= link_rd;
						link_mem[cur_q] <= recyc_q;
					end
				endcase
			end else begin
				prev_q      <= cur_q;
				have_prev_q <= 1'b1;
			end
		end
		if (st_q == cht_pkg::ST_ALLOC && op_q == cht_pkg::OP_SET) begin
			if (new_slot_ok) begin
				ent_mem[new_slot]  <= {val_q, len_q, key_q};
				link_mem[new_slot] <= '0;
				if (have_prev_q) link_mem[prev_q] <= {1'b1, new_slot};
				else head_mem[bkt_q] <= {1'b1, new_slot};
			end else begin
				full_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, 11'(total_q), full_q, rval_q, found_q};
endmodule

// File: rtl/cht_checker.sv
// ---------------------------------------------------------------------------
// cht_checker
// port-level checks of the hash table engine
// ---------------------------------------------------------------------------
`include "chained_hash_table_engine_top_macros.svh"
module cht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        pready
);
	`CHT_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_axis_tvalid, !s_axis_tready, "request taken while result pending")
	`CHT_ASSERT_NEXT(a_out_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed")
	`CHT_ASSERT_IMP(a_full_not_found, clk, arst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[33]), "full and found together")
	`CHT_ASSERT_IMP(a_pready, clk, arst_n, 1'b1, pready, "pready low")
endmodule

bind chained_hash_table_engine_top cht_checker u_cht_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .pready(pready)
);

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the chained hash table engine: every accepted
// request is run through a behavioural copy of the table kept here, and each
// response on the output stream is compared field by field with the oldest
// prediction; directed cases, a pool fill and random traffic under
// several size settings and idle/stall mixes
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// unassigned operation code, must leave the table alone
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int NUM_BUCKETS = 1024;
	localparam int NUM_ENTRIES = 1024;
	localparam int MAX_KEY_BYTES = 8;
	// walks over long chains at heavy stall, plus the head clear after reset
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 64;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// operation[1:0], key_bytes[65:2], key_length[69:66], value[101:70], pad
	logic [103:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// found[0], result_value[32:1], full_res[33], entry_count[44:34], pad
	logic [47:0] m_axis_tdata;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	chained_hash_table_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// one stored pair as the table holds it
	typedef struct {
		logic [63:0] key;
		logic [3:0]  len;
		logic [31:0] val;
	} kv_pair_t;

	// one response as it leaves the engine
	typedef struct {
		logic        found;
		logic [31:0] value;
		logic        full;
		logic [10:0] count;
	} lookup_resp_t;

	// shadow table: each bucket chain kept in walk order, head first
	kv_pair_t     bucket_chain[NUM_BUCKETS][$];
	int unsigned  stored_pairs;
	logic [2:0]   size_sel;
	lookup_resp_t pending_resp[$];

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned errors;
	int unsigned requests_sent;
	int unsigned responses_seen;
	int unsigned full_seen;
	int unsigned hits_seen;
	longint unsigned cycles;

	// keys reused by the random traffic so that hits and removes happen
	logic [63:0] hot_key[24];
	logic [3:0]  hot_len[24];

	// clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// guard against a hung engine
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver back-pressure, ready dropped with a chance of stall_pct percent
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// djb2 over the valid key bytes, masked to the bucket count in use
	function automatic int unsigned bucket_index(logic [63:0] key, int unsigned n);
		logic [31:0] h;
		int unsigned sel;
		h = cht_pkg::HASH_SEED;
		sel = (size_sel > cht_pkg::MAX_SELECT) ? cht_pkg::MAX_SELECT : size_sel;
		for (int i = 0; i < n; i++) begin
			h = h * 32'd33 + {24'd0, key[8*i +: 8]};
		end
		return h & ((NUM_BUCKETS >> sel) - 1);
	endfunction

	// apply one request to the shadow table and return the response it gives
	function automatic lookup_resp_t table_update(logic [1:0] op, logic [63:0] key,
			logic [3:0] len, logic [31:0] val);
		lookup_resp_t r;
		int unsigned n;
		int unsigned b;
		int pos;
		logic [63:0] k;
		kv_pair_t p;
		r = '{found: 1'b0, value: 32'd0, full: 1'b0, count: 11'd0};
		n = (len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : len;
		// bytes above the length take no part in hashing or identity
		k = (n == MAX_KEY_BYTES) ? key : key & ((64'd1 << (8 * n)) - 64'd1);
		if (op != OP_UNUSED) begin
			b = bucket_index(k, n);
			pos = -1;
			foreach (bucket_chain[b][i]) begin
				if (pos < 0 && bucket_chain[b][i].len == n && bucket_chain[b][i].key == k)
					pos = i;
			end
			case (op)
				cht_pkg::OP_SET: begin
					if (pos >= 0) begin
						bucket_chain[b][pos].val = val;
						r.found = 1'b1;
					end else if (stored_pairs >= NUM_ENTRIES) begin
						// pool exhausted, table untouched
						r.full = 1'b1;
					end else begin
						p.key = k;
						p.len = 4'(n);
						p.val = val;
						bucket_chain[b].push_back(p);
						stored_pairs++;
					end
				end
				cht_pkg::OP_GET: begin
					if (pos >= 0) begin
						r.found = 1'b1;
						r.value = bucket_chain[b][pos].val;
					end
				end
				default: begin
					if (pos >= 0) begin
						bucket_chain[b].delete(pos);
						stored_pairs--;
						r.found = 1'b1;
					end
				end
			endcase
		end
		r.count = 11'(stored_pairs);
		return r;
	endfunction

	// send one request, with a random gap before it when the sender idles
	task automatic send_request(logic [1:0] op, logic [63:0] key, logic [3:0] len,
			logic [31:0] val);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, val, len, key, op};
		do @(posedge clk); while (!s_axis_tready);
		// accepted at this edge, predict in acceptance order
		pending_resp.push_back(table_update(op, key, len, val));
		requests_sent++;
	endtask

	// let every outstanding response come back, then a little extra
	task automatic drain_responses();
		s_axis_tvalid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write with setup and access phases, only with the engine idle
	task automatic write_size_select(logic [31:0] data);
		drain_responses();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'(4 * cht_pkg::REG_SIZE_SELECT);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		size_sel = data[2:0];
	endtask

	// response checker, oldest prediction first
	always @(posedge clk) begin
		lookup_resp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			responses_seen++;
			if (pending_resp.size() == 0) begin
				$error("response with no request outstanding: %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_resp.pop_front();
				if (want.found) hits_seen++;
				if (want.full) full_seen++;
				if (m_axis_tdata[0] !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, m_axis_tdata[0]);
					errors++;
				end
				if (m_axis_tdata[32:1] !== want.value) begin
					$error("result_value: expected %h, got %h", want.value,
						m_axis_tdata[32:1]);
					errors++;
				end
				if (m_axis_tdata[33] !== want.full) begin
					$error("full_res: expected %0d, got %0d", want.full, m_axis_tdata[33]);
					errors++;
				end
				if (m_axis_tdata[44:34] !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count,
						m_axis_tdata[44:34]);
					errors++;
				end
			end
		end
	end

	// extremes of every field, each operation and the odd cases
	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		send_request(cht_pkg::OP_GET, 64'd0, 4'd0, 32'd0);        // lookup in empty table
		send_request(cht_pkg::OP_REM, 64'd5, 4'd1, 32'd0);        // remove a missing key
		// empty key, extra bytes ignored
		send_request(cht_pkg::OP_SET, 64'hdead, 4'd0, 32'hffff_ffff);
		send_request(cht_pkg::OP_GET, 64'd0, 4'd0, 32'd0);
		send_request(cht_pkg::OP_SET, '1, 4'd8, 32'h1234_5678);   // longest key, all ones
		send_request(cht_pkg::OP_SET, '1, 4'd15, 32'h0);          // length saturates, so update
		send_request(cht_pkg::OP_GET, '1, 4'd8, 32'hffff_ffff);   // value ignored on lookup
		// high bytes beyond length
		send_request(cht_pkg::OP_SET, 64'h00ff_ff01, 4'd2, 32'haaaa_5555);
		send_request(cht_pkg::OP_GET, 64'h0000_ff01, 4'd2, 32'd0);
		// length is part of identity
		send_request(cht_pkg::OP_GET, 64'h0000_ff01, 4'd3, 32'd0);
		send_request(cht_pkg::OP_SET, 64'h0000_ff01, 4'd3, 32'h5555_aaaa);
		send_request(OP_UNUSED, 64'h0000_ff01, 4'd2, 32'd7);      // unused code, no change
		send_request(OP_UNUSED, '1, 4'hf, '1);
		send_request(cht_pkg::OP_REM, 64'h0000_ff01, 4'd2, 32'd0);
		send_request(cht_pkg::OP_GET, 64'h0000_ff01, 4'd2, 32'd0);
		send_request(cht_pkg::OP_GET, 64'h0000_ff01, 4'd3, 32'd0);
		send_request(cht_pkg::OP_REM, '1, 4'd9, 32'd0);
		send_request(cht_pkg::OP_REM, '1, 4'd8, 32'd0);           // already gone
		send_request(cht_pkg::OP_SET, 64'h8000_0000_0000_0000, 4'd8, 32'h8000_0001);
		send_request(cht_pkg::OP_GET, 64'h8000_0000_0000_0000, 4'd8, 32'd0);
		send_request(cht_pkg::OP_REM, 64'd0, 4'd0, 32'd0);
	endtask

	// fill the pool, then probe behaviour while it is exhausted
	task automatic test_pool_full();
		write_size_select(32'd0);
		idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			send_request(cht_pkg::OP_SET, 64'(i) | 64'hab00_0000, 4'd4, $urandom);
		end
		send_request(cht_pkg::OP_SET, 64'h77, 4'd1, 32'd1);       // new key rejected
		// update still allowed
		send_request(cht_pkg::OP_SET, 64'hab00_0010, 4'd4, 32'hcafe_f00d);
		send_request(cht_pkg::OP_GET, 64'hab00_0010, 4'd4, 32'd0);
		send_request(cht_pkg::OP_REM, 64'hab00_0011, 4'd4, 32'd0); // frees a slot
		send_request(cht_pkg::OP_SET, 64'h77, 4'd1, 32'd2);       // now accepted
		send_request(cht_pkg::OP_SET, 64'h78, 4'd1, 32'd3);       // full again
	endtask

	// random traffic, mostly on a small set of reused keys
	task automatic test_random_phase(logic [31:0] size_data, int unsigned idle,
			int unsigned stall, int unsigned count);
		logic [1:0] op;
		logic [63:0] key;
		logic [3:0] len;
		int unsigned pick;
		int unsigned j;
		write_size_select(size_data);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			op = (pick < 40) ? cht_pkg::OP_SET : (pick < 68) ? cht_pkg::OP_GET :
				(pick < 95) ? cht_pkg::OP_REM : OP_UNUSED;
			pick = $urandom_range(99);
			if (pick < 55) begin
				j = $urandom_range(23);
				key = hot_key[j];
				len = hot_len[j];
				// garbage above the length must not matter
				if ($urandom_range(3) == 0 && len < MAX_KEY_BYTES)
					key = key | ({$urandom, $urandom} << (8 * len));
			end else if (pick < 80) begin
				// one of the fill keys, frees slots for new ones
				key = 64'($urandom_range(NUM_ENTRIES - 1)) | 64'hab00_0000;
				len = 4'd4;
			end else begin
				key = {$urandom, $urandom};
				len = 4'($urandom_range(15));
			end
			send_request(op, key, len, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		requests_sent = 0;
		responses_seen = 0;
		full_seen = 0;
		hits_seen = 0;
		cycles = 0;
		stored_pairs = 0;
		size_sel = 3'd0;
		foreach (hot_key[i]) begin
			hot_key[i] = {$urandom, $urandom};
			hot_len[i] = 4'($urandom_range(MAX_KEY_BYTES));
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_pool_full();
		// every idling mix, extremes of the size register among them
		test_random_phase(32'd6, 0, 0, 100);
		test_random_phase(32'hffff_fff7, 78, 0, 100);
		test_random_phase(32'd3, 0, 78, 100);
		test_random_phase(32'd0, 35, 35, 100);

		drain_responses();
		$display("covered %0d requests and %0d responses: %0d hits, %0d rejected as full",
			requests_sent, responses_seen, hits_seen, full_seen);
		$display("size settings 0, 3, 6 and saturated 7, under four idle/stall mixes");
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
